// ===== design/lcg_ranged_random_generator_unit_defines.svh =====
// Assertion macros for the ranged LCG generator.
// No dependencies; taken in by files that assert.
`ifndef LCG_RANGED_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define LCG_RANGED_RANDOM_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LRG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrg assertion failed");
`define LRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrg assertion failed");
`else
`define LRG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/lrg_pkg.sv =====
// Types and constants shared by the ranged LCG generator.
// No dependencies.
package lrg_pkg;

    localparam logic [31:0] LcgMul   = 32'd214013;
    localparam logic [31:0] LcgAdd   = 32'd2531011;
    localparam logic [31:0] SeedInit = 32'd1;
    localparam int          DrawBits = 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP1,
        ST_STEP2,
        ST_SCALE,
        ST_FINISH
    } lrg_state_t;

    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic scale;
        logic finish;
    } lrg_cmd_t;

    typedef struct packed {
        logic in_equal;
        logic out_free;
    } lrg_status_t;

    function automatic logic [31:0] lcg_next(input logic [31:0] s);
        logic [31:0] prod;
        prod = s * LcgMul;
        return prod + LcgAdd;
    endfunction

endpackage

// ===== design/lcg_ranged_random_generator_unit.sv =====
// Ranged random number generator built on a 32-bit LCG.
// Depends on lrg_pkg, lrg_controller, lrg_datapath and the defines header.
//
// Use:
//   Slave channel s_axis_* takes one request word: bounds begin and end.
//   Master channel m_axis_* returns one word per request: begin plus the
//   scaled 30-bit draw, modulo 2^32. Equal bounds return begin and leave the
//   generator state untouched.
//   cfg_wr_en/cfg_wr_data write the seed; the state is reloaded from it.
//   Write the seed only while no request is in flight.
// Sequence:
//   Normal request: the states STEP1, STEP2, SCALE and FINISH follow
//   acceptance, and the next request is taken only back in IDLE. The two
//   LCG steps share one constant multiplier, one after the other, then
//   the SCALE step scales the draw. Equal bounds: FINISH follows acceptance
//   directly, then IDLE takes the next request.
// Reset: state set to 1, no result pending, s_axis_tready high.
// Stall: a held result sits in the output register; one further request is
//   accepted and computed, then waits until the output word is taken.
`include "lcg_ranged_random_generator_unit_defines.svh"

module lcg_ranged_random_generator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] range_begin, [63:32] range_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] random_value
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data     // start_seed
);

    lrg_pkg::lrg_cmd_t    cmd;
    lrg_pkg::lrg_status_t status;

    lrg_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    lrg_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_data     (s_axis_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_axis_tready),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata)
    );

    `LRG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `LRG_ASSERT_IMP(a_finish_slot_free, clk, rst_n, cmd.finish, !m_axis_tvalid || m_axis_tready)
    `LRG_ASSERT_IMP(a_step2_after_step1, clk, rst_n, cmd.step2, $past(cmd.step1))

endmodule

// ===== design/lrg_controller.sv =====
// Sequencing state machine of the ranged LCG generator.
// Depends on lrg_pkg.
module lrg_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  lrg_pkg::lrg_status_t status,
    output logic                 in_ready,
    output lrg_pkg::lrg_cmd_t    cmd
);

    lrg_pkg::lrg_state_t state_reg;
    lrg_pkg::lrg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.in_equal ? lrg_pkg::ST_FINISH : lrg_pkg::ST_STEP1;
                end
            end
            lrg_pkg::ST_STEP1:  state_next = lrg_pkg::ST_STEP2;
            lrg_pkg::ST_STEP2:  state_next = lrg_pkg::ST_SCALE;
            lrg_pkg::ST_SCALE:  state_next = lrg_pkg::ST_FINISH;
            lrg_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = lrg_pkg::ST_IDLE;
                end
            end
            default:            state_next = lrg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            lrg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            lrg_pkg::ST_STEP1:  cmd.step1  = 1'b1;
            lrg_pkg::ST_STEP2:  cmd.step2  = 1'b1;
            lrg_pkg::ST_SCALE:  cmd.scale  = 1'b1;
            lrg_pkg::ST_FINISH: cmd.finish = status.out_free;
            default:            cmd        = '0;
        endcase
    end

endmodule

// ===== design/lrg_datapath.sv =====
// Datapath of the ranged LCG generator: state, draw, scaling and output word.
// Depends on lrg_pkg.
module lrg_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrg_pkg::lrg_cmd_t    cmd,
    input  logic [63:0]          in_data,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 out_ready,
    output lrg_pkg::lrg_status_t status,
    output logic                 out_valid,
    output logic [31:0]          out_data
);

    logic [31:0] lcg_reg;
    logic [31:0] begin_reg;
    logic [31:0] span_reg;
    logic [29:0] draw_reg;
    logic [31:0] scaled_reg;
    logic [31:0] out_data_reg;
    logic        out_valid_reg;
    logic [31:0] lcg_step;
    logic [61:0] product;

    assign lcg_step = lrg_pkg::lcg_next(lcg_reg);
    assign product  = 62'(draw_reg) * 62'(span_reg);

    assign status.in_equal = (in_data[31:0] == in_data[63:32]);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg       <= lrg_pkg::SeedInit;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lcg_reg <= cfg_wr_data;
            end
            else if (cmd.step1 || cmd.step2)
            begin
                lcg_reg <= lcg_step;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            begin_reg  <= in_data[31:0];
            span_reg   <= in_data[63:32] - in_data[31:0];
            scaled_reg <= '0;
        end
        if (cmd.step2)
        begin
            // first new state is in lcg_reg, second is being formed
            draw_reg <= {lcg_step[30:16], lcg_reg[30:16]};
        end
        if (cmd.scale)
        begin
            scaled_reg <= product[61:lrg_pkg::DrawBits];
        end
        if (cmd.finish)
        begin
            out_data_reg <= begin_reg + scaled_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== test/lcg_ranged_random_generator_unit_test.sv =====
// Self-checking testbench for lcg_ranged_random_generator_unit: random request words
// are checked against an in-bench prediction of the LCG draw, under several seeds.
// Depends on lrg_pkg and the unit itself.
module lcg_ranged_random_generator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit     = 2000;
    localparam int HoldOffCycles = 150;
    localparam int ItemsPerSeed  = 110;
    localparam int SettleCycles  = 8;

    class ranged_draw_scoreboard;
        logic [31:0] lcg_state;
        logic [31:0] expected_values[$];
        int unsigned failures;

        function new();
            lcg_state = lrg_pkg::SeedInit;
            failures = 0;
        endfunction

        function void load_seed(input logic [31:0] seed);
            lcg_state = seed;
        endfunction

        function void note_request(input logic [31:0] lo, input logic [31:0] hi);
            logic [31:0] first;
            logic [31:0] second;
            logic [31:0] span;
            logic [29:0] draw;
            logic [63:0] product;
            if (lo == hi)
            begin
                expected_values.insert(expected_values.size(), lo);
                return;
            end
            first = lcg_state * lrg_pkg::LcgMul + lrg_pkg::LcgAdd;
            second = first * lrg_pkg::LcgMul + lrg_pkg::LcgAdd;
            lcg_state = second;
            draw = {second[30:16], first[30:16]};
            span = hi - lo;
            product = {34'd0, draw} * {32'd0, span};
            expected_values.insert(expected_values.size(), lo + product[61:30]);
        endfunction

        function void check_value(input logic [31:0] actual);
            logic [31:0] want;
            if (expected_values.size() == 0)
            begin
                $error("random_value: expected nothing, got %h", actual);
                failures++;
                return;
            end
            want = expected_values.pop_front();
            if (actual !== want)
            begin
                $error("random_value: expected %h, got %h", want, actual);
                failures++;
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] range_begin, [63:32] range_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] random_value
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    ranged_draw_scoreboard sb;
    int          idle_cycles = 0;
    int          burst_left;
    bit          hold_off_due;

    lcg_ranged_random_generator_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.load_seed(cfg_wr_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_value(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: stall pattern switches among four modes, chosen at random
    initial
    begin : receiver
        int mode;
        int left;
        m_axis_tready = 1'b0;
        mode = 0;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_due)
            begin
                m_axis_tready <= 1'b0;
                repeat (HoldOffCycles) @(negedge clk);
                hold_off_due = 1'b0;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic offer(input logic [31:0] lo, input logic [31:0] hi);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata <= {hi, lo};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        cfg_wr_data <= seed;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
        lo = $urandom;
        case ($urandom_range(0, 9))
            0:       hi = lo;
            1:       hi = lo + $urandom_range(1, 16);
            2:       hi = lo - $urandom_range(1, 1000);
            3:
            begin
                lo = 32'd0;
                hi = $urandom;
            end
            4:       hi = 32'hffff_ffff;
            default: hi = $urandom;
        endcase
    endtask

    initial
    begin : stimulus
        logic [31:0] dir_lo [18];
        logic [31:0] dir_hi [18];
        logic [31:0] seeds [5];
        logic [31:0] lo;
        logic [31:0] hi;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        burst_left = 0;
        hold_off_due = 1'b0;
        sb = new();

        // equal bounds, span of one, full span, wrap of end below begin
        dir_lo = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
                   32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'hffff_fffe,
                   32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h1234_5678,
                   32'h0000_0005, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0000,
                   32'h0000_0100, 32'hffff_0000};
        dir_hi = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
                   32'h0000_0001, 32'h0000_0000, 32'hffff_fffe, 32'hffff_ffff,
                   32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678,
                   32'h0000_0003, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001,
                   32'h0000_0200, 32'h0000_0010};
        seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h8000_0000};
        seeds[2] = $urandom;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset seed still in force here
        foreach (dir_lo[i])
            offer(dir_lo[i], dir_hi[i]);
        drain();

        hold_off_due = 1'b1;
        foreach (seeds[p])
        begin
            load_seed(seeds[p]);
            repeat (ItemsPerSeed)
            begin
                pick_bounds(lo, hi);
                offer(lo, hi);
            end
            drain();
        end

        if (sb.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
